[hw/rtl/arp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package arp_pkg;
    localparam int CACHE_DEPTH_DEF = 16;
    localparam int REQ_DEPTH_DEF   = 8;

    localparam logic [2:0] ACT_LOOKUP = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_QUEUE  = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_TICK   = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;

    localparam logic [2:0] KIND_LOOKUP = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_QUEUE  = 3'd2;
    localparam logic [2:0] KIND_SEND   = 3'd3;
    localparam logic [2:0] KIND_DROP   = 3'd4;
    localparam logic [2:0] KIND_DONE   = 3'd5;

    localparam logic [7:0] TIMEOUT_RST = 8'd30;
    localparam logic [3:0] MAXSEND_RST = 4'd5;

    localparam logic [0:0] REG_TIMEOUT = 1'b0;
    localparam logic [0:0] REG_MAXSEND = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic        hit;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [3:0]  iface;
        logic        full;
        logic        last;
    } arp_result_t;
endpackage
`default_nettype wire

[hw/rtl/arp_cache_with_aging_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake               Payload
// in        in_valid / in_ready     action, target_ip, mac_addr, iface_index
// out       out_valid / out_ready   kind, hit, out_mac, out_ip, out_iface, table_full, last
// cfg       psel/penable/pwrite     paddr, pwdata, prdata, pready (always high)
//
// Each accepted item walks the cache slots for lookup, the request slots for queue/remove,
// both for insert and tick; clear and unknown actions go straight to the result. A single
// compare / age-update unit visits one slot per cycle; the tick request walk can stall.
// Reset clears the valid bits and config; slot payload is left as is.
// A result waits in the output register; a stall there holds the tick request walk and emit.
module arp_cache_with_aging_core #(
    parameter int CACHE_DEPTH = arp_pkg::CACHE_DEPTH_DEF,
    parameter int REQ_DEPTH   = arp_pkg::REQ_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [2:0]  action,
    input  wire  [31:0] target_ip,
    input  wire  [47:0] mac_addr,
    input  wire  [3:0]  iface_index,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [2:0]  kind,
    output logic        hit,
    output logic [47:0] out_mac,
    output logic [31:0] out_ip,
    output logic [3:0]  out_iface,
    output logic        table_full,
    output logic        last,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import arp_pkg::*;

    localparam int CW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int RW = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CWALK = 3'd1;  // cache scan
    localparam logic [2:0] ST_RWALK = 3'd2;  // request scan
    localparam logic [2:0] ST_EMIT  = 3'd3;  // final result
    localparam logic [2:0] ST_TREQ  = 3'd4;  // tick request walk

    // configuration
    logic [7:0] timeout_reg;
    logic [3:0] maxsend_reg;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            maxsend_reg <= MAXSEND_RST;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_TIMEOUT)
            begin
                timeout_reg <= pwdata[7:0];
            end
            else
            begin
                maxsend_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_TIMEOUT)
            begin
                prdata = {24'd0, timeout_reg};
            end
            else
            begin
                prdata = {28'd0, maxsend_reg};
            end
        end
    end

    // slot storage; valid bits reset, payload does not
    logic [CACHE_DEPTH-1:0] cvalid_reg;
    logic [31:0]            cip_mem  [CACHE_DEPTH];
    logic [47:0]            cmac_mem [CACHE_DEPTH];
    logic [7:0]             cage_mem [CACHE_DEPTH];
    logic [REQ_DEPTH-1:0]   rvalid_reg;
    logic [31:0]            rip_mem  [REQ_DEPTH];
    logic [3:0]             rif_mem  [REQ_DEPTH];
    logic [3:0]             rsent_mem[REQ_DEPTH];

    // sequencer
    logic [2:0]  state_reg;
    logic [2:0]  act_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [3:0]  if_reg;
    logic [CW:0] ci_reg;
    logic [RW:0] ri_reg;
    logic        found_reg;     // lookup hit / insert slot found
    logic [CW-1:0] fslot_reg;   // chosen cache slot
    logic [47:0] fmac_reg;
    logic        rfound_reg;    // request for ip pending
    logic        rfree_reg;
    logic [RW-1:0] rslot_reg;   // lowest free request slot

    logic        ob_busy;
    logic        ld;
    arp_result_t ld_data;
    arp_result_t od;

    arp_out_reg u_out (
        .clk(clk), .rst_n(rst_n), .load(ld), .load_data(ld_data),
        .busy(ob_busy), .out_valid(out_valid), .out_ready(out_ready), .out_data(od)
    );

    assign kind       = od.kind;
    assign hit        = od.hit;
    assign out_mac    = od.mac;
    assign out_ip     = od.ip;
    assign out_iface  = od.iface;
    assign table_full = od.full;
    assign last       = od.last;

    assign in_ready = (state_reg == ST_IDLE);

    logic [CW-1:0] cidx;
    logic [RW-1:0] ridx;
    logic [7:0]    age_inc;
    assign cidx    = ci_reg[CW-1:0];
    assign ridx    = ri_reg[RW-1:0];
    assign age_inc = (cage_mem[cidx] == 8'hFF) ? 8'hFF : cage_mem[cidx] + 8'd1;

    logic c_end, r_end;
    assign c_end = (ci_reg == (CW+1)'(CACHE_DEPTH - 1));
    assign r_end = (ri_reg == (RW+1)'(REQ_DEPTH - 1));

    always_comb
    begin
        ld      = 1'b0;
        ld_data = '0;
        if (!ob_busy)
        begin
            if (state_reg == ST_EMIT)
            begin
                ld = 1'b1;
                ld_data.last = 1'b1;
                unique case (act_reg)
                    ACT_LOOKUP:
                    begin
                        ld_data.kind = KIND_LOOKUP;
                        ld_data.hit  = found_reg;
                        ld_data.mac  = found_reg ? fmac_reg : 48'd0;
                    end
                    ACT_INSERT:
                    begin
                        ld_data.kind = KIND_INSERT;
                        ld_data.hit  = rfound_reg;
                        ld_data.full = !found_reg;
                    end
                    ACT_QUEUE:
                    begin
                        ld_data.kind = KIND_QUEUE;
                        ld_data.hit  = !rfound_reg && rfree_reg;
                        ld_data.full = !rfound_reg && !rfree_reg;
                    end
                    default:
                    begin
                        ld_data.kind = KIND_DONE;
                    end
                endcase
            end
            else if (state_reg == ST_TREQ && rvalid_reg[ridx])
            begin
                ld = 1'b1;
                ld_data.kind  = (rsent_mem[ridx] >= maxsend_reg) ? KIND_DROP : KIND_SEND;
                ld_data.ip    = rip_mem[ridx];
                ld_data.iface = rif_mem[ridx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cvalid_reg <= '0;
            rvalid_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        unique case (action)
                            ACT_LOOKUP, ACT_INSERT, ACT_TICK: state_reg <= ST_CWALK;
                            ACT_QUEUE, ACT_REMOVE:            state_reg <= ST_RWALK;
                            ACT_CLEAR:
                            begin
                                cvalid_reg <= '0;
                                rvalid_reg <= '0;
                                state_reg  <= ST_EMIT;
                            end
                            default: state_reg <= ST_EMIT;
                        endcase
                    end
                end
                ST_CWALK:
                begin
                    // age and expire one slot per cycle on tick
                    if (act_reg == ACT_TICK && cvalid_reg[cidx] && age_inc > timeout_reg)
                    begin
                        cvalid_reg[cidx] <= 1'b0;
                    end
                    if (c_end)
                    begin
                        if (act_reg == ACT_LOOKUP)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else if (act_reg == ACT_TICK)
                        begin
                            state_reg <= ST_TREQ;
                        end
                        else
                        begin
                            state_reg <= ST_RWALK;
                        end
                    end
                end
                ST_RWALK:
                begin
                    if (act_reg == ACT_REMOVE && rvalid_reg[ridx] && rip_mem[ridx] == ip_reg)
                    begin
                        rvalid_reg[ridx] <= 1'b0;
                    end
                    if (r_end)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_TREQ:
                begin
                    if (!ob_busy)
                    begin
                        if (rvalid_reg[ridx] && rsent_mem[ridx] >= maxsend_reg)
                        begin
                            rvalid_reg[ridx] <= 1'b0;
                        end
                        if (r_end)
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!ob_busy)
                    begin
                        if (act_reg == ACT_INSERT && found_reg)
                        begin
                            cvalid_reg[fslot_reg] <= 1'b1;
                        end
                        if (act_reg == ACT_QUEUE && !rfound_reg && rfree_reg)
                        begin
                            rvalid_reg[rslot_reg] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath: counters, capture, slot payload writes
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                act_reg    <= action;
                ip_reg     <= target_ip;
                mac_reg    <= mac_addr;
                if_reg     <= iface_index;
                ci_reg     <= '0;
                ri_reg     <= '0;
                found_reg  <= 1'b0;
                rfound_reg <= 1'b0;
                rfree_reg  <= 1'b0;
                fslot_reg  <= '0;
                rslot_reg  <= '0;
                fmac_reg   <= '0;
            end
            ST_CWALK:
            begin
                ci_reg <= ci_reg + 1'b1;
                if (!found_reg)
                begin
                    if (act_reg == ACT_LOOKUP && cvalid_reg[cidx] && cip_mem[cidx] == ip_reg)
                    begin
                        found_reg <= 1'b1;
                        fmac_reg  <= cmac_mem[cidx];
                    end
                    if (act_reg == ACT_INSERT && !cvalid_reg[cidx])
                    begin
                        found_reg <= 1'b1;
                        fslot_reg <= cidx;
                    end
                end
                if (act_reg == ACT_TICK && cvalid_reg[cidx])
                begin
                    cage_mem[cidx] <= age_inc;
                end
            end
            ST_RWALK:
            begin
                ri_reg <= ri_reg + 1'b1;
                if (rvalid_reg[ridx] && rip_mem[ridx] == ip_reg)
                begin
                    rfound_reg <= 1'b1;
                end
                if (!rfree_reg && !rvalid_reg[ridx])
                begin
                    rfree_reg <= 1'b1;
                    rslot_reg <= ridx;
                end
            end
            ST_TREQ:
            begin
                if (!ob_busy)
                begin
                    ri_reg <= ri_reg + 1'b1;
                    if (rvalid_reg[ridx] && rsent_mem[ridx] < maxsend_reg)
                    begin
                        rsent_mem[ridx] <= rsent_mem[ridx] + 4'd1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!ob_busy)
                begin
                    if (act_reg == ACT_INSERT && found_reg)
                    begin
                        cip_mem[fslot_reg]  <= ip_reg;
                        cmac_mem[fslot_reg] <= mac_reg;
                        cage_mem[fslot_reg] <= 8'd0;
                    end
                    if (act_reg == ACT_QUEUE && !rfound_reg && rfree_reg)
                    begin
                        rip_mem[rslot_reg]   <= ip_reg;
                        rif_mem[rslot_reg]   <= if_reg;
                        rsent_mem[rslot_reg] <= 4'd0;
                    end
                end
            end
            default:
            begin
                ci_reg <= '0;
            end
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/arp_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
module arp_out_reg (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  load,
    input  arp_pkg::arp_result_t load_data,
    output logic                 busy,
    output logic                 out_valid,
    input  wire                  out_ready,
    output arp_pkg::arp_result_t out_data
);
    import arp_pkg::*;

    logic        valid_reg;
    arp_result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    // loading is allowed when empty or being drained this cycle
    assign busy      = valid_reg && !out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Scoreboard: holds the expected results of every accepted item, oldest first.
class arp_scoreboard;
    arp_pkg::arp_result_t pending_q[$];
    int                   error_count;

    // Shadow tables, advanced per accepted item by note_item, which also queues its results.
    bit          c_valid [16];
    logic [31:0] c_ip    [16];
    logic [47:0] c_mac   [16];
    logic [7:0]  c_age   [16];
    bit          r_valid [8];
    logic [31:0] r_ip    [8];
    logic [3:0]  r_iface [8];
    logic [3:0]  r_sent  [8];
    logic [7:0]  timeout;
    logic [3:0]  max_sends;

    function new();
        timeout   = arp_pkg::TIMEOUT_RST;
        max_sends = arp_pkg::MAXSEND_RST;
        wipe();
    endfunction

    function void wipe();
        foreach (c_valid[i]) c_valid[i] = 0;
        foreach (r_valid[i]) r_valid[i] = 0;
    endfunction

    function void push(logic [2:0] kind, bit hit, logic [47:0] mac, logic [31:0] ip,
                       logic [3:0] iface, bit full, bit last);
        arp_pkg::arp_result_t r;
        r.kind = kind; r.hit = hit; r.mac = mac; r.ip = ip;
        r.iface = iface; r.full = full; r.last = last;
        pending_q.insert(pending_q.size(), r);
    endfunction

    function int req_slot(logic [31:0] ip);
        for (int i = 0; i < 8; i++)
            if (r_valid[i] && r_ip[i] == ip) return i;
        return -1;
    endfunction

    function void note_item(logic [2:0] act, logic [31:0] ip, logic [47:0] mac,
                            logic [3:0] iface);
        bit found;
        bit full;
        bit made;
        found = 0; full = 1; made = 0;
        case (act)
            arp_pkg::ACT_LOOKUP: begin
                for (int i = 0; i < 16 && !found; i++)
                    if (c_valid[i] && c_ip[i] == ip) begin
                        push(arp_pkg::KIND_LOOKUP, 1, c_mac[i], 0, 0, 0, 1);
                        found = 1;
                    end
                if (!found) push(arp_pkg::KIND_LOOKUP, 0, 0, 0, 0, 0, 1);
            end
            arp_pkg::ACT_INSERT: begin
                for (int i = 0; i < 16 && full; i++)
                    if (!c_valid[i]) begin
                        c_valid[i] = 1; c_ip[i] = ip; c_mac[i] = mac; c_age[i] = 0;
                        full = 0;
                    end
                push(arp_pkg::KIND_INSERT, req_slot(ip) >= 0, 0, 0, 0, full, 1);
            end
            arp_pkg::ACT_QUEUE: begin
                if (req_slot(ip) < 0) begin
                    for (int i = 0; i < 8 && !made; i++)
                        if (!r_valid[i]) begin
                            r_valid[i] = 1; r_ip[i] = ip; r_iface[i] = iface; r_sent[i] = 0;
                            made = 1;
                        end
                end else full = 0;
                push(arp_pkg::KIND_QUEUE, made, 0, 0, 0, full && !made, 1);
            end
            arp_pkg::ACT_REMOVE: begin
                foreach (r_valid[i])
                    if (r_valid[i] && r_ip[i] == ip) r_valid[i] = 0;
                push(arp_pkg::KIND_DONE, 0, 0, 0, 0, 0, 1);
            end
            arp_pkg::ACT_TICK: begin
                foreach (c_valid[i])
                    if (c_valid[i]) begin
                        if (c_age[i] != 8'hFF) c_age[i]++;
                        if (c_age[i] > timeout) c_valid[i] = 0;
                    end
                foreach (r_valid[i])
                    if (r_valid[i]) begin
                        if (r_sent[i] >= max_sends) begin
                            r_valid[i] = 0;
                            push(arp_pkg::KIND_DROP, 0, 0, r_ip[i], r_iface[i], 0, 0);
                        end else begin
                            push(arp_pkg::KIND_SEND, 0, 0, r_ip[i], r_iface[i], 0, 0);
                            r_sent[i]++;
                        end
                    end
                push(arp_pkg::KIND_DONE, 0, 0, 0, 0, 0, 1);
            end
            arp_pkg::ACT_CLEAR: begin
                wipe();
                push(arp_pkg::KIND_DONE, 0, 0, 0, 0, 0, 1);
            end
            default: push(arp_pkg::KIND_DONE, 0, 0, 0, 0, 0, 1);
        endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    task check_result(arp_pkg::arp_result_t got);
        arp_pkg::arp_result_t want;
        if (pending_q.size() == 0) begin
            report("unexpected result kind", 64'(got.kind), 64'd0);
            return;
        end
        want = pending_q.pop_front();
        if (got.kind  !== want.kind)  report("kind", 64'(got.kind), 64'(want.kind));
        if (got.hit   !== want.hit)   report("hit", 64'(got.hit), 64'(want.hit));
        if (got.mac   !== want.mac)   report("out_mac", 64'(got.mac), 64'(want.mac));
        if (got.ip    !== want.ip)    report("out_ip", 64'(got.ip), 64'(want.ip));
        if (got.iface !== want.iface) report("out_iface", 64'(got.iface), 64'(want.iface));
        if (got.full  !== want.full)  report("table_full", 64'(got.full), 64'(want.full));
        if (got.last  !== want.last)  report("last", 64'(got.last), 64'(want.last));
    endtask
endclass

module tb_top;
    import arp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [31:0] target_ip;
    logic [47:0] mac_addr;
    logic [3:0]  iface_index;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic        hit;
    logic [47:0] out_mac;
    logic [31:0] out_ip;
    logic [3:0]  out_iface;
    logic        table_full;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    arp_scoreboard arp_sb;
    int            cycle_count;
    bit            stim_done;
    // Small pool of addresses so lookups, duplicates and removals actually hit.
    logic [31:0]   ip_pool [8];

    arp_cache_with_aging_core i_dut (.*);

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Random gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receive side: stall at random, check each accepted result.
    initial begin
        arp_result_t got;
        out_ready = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got.kind = kind; got.hit = hit; got.mac = out_mac; got.ip = out_ip;
                got.iface = out_iface; got.full = table_full; got.last = last;
                arp_sb.check_result(got);
            end
            // Hold ready low at random, otherwise keep it high.
            if (stim_done || $urandom_range(0, 3) != 0) out_ready <= 1;
            else out_ready <= 0;
        end
    end

    // Watchdog: end the run at a generous cycle limit.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Drive one item and wait until the block accepts it.
    task automatic send_item(logic [2:0] act, logic [31:0] ip, logic [47:0] mac,
                             logic [3:0] iface);
        int gap;
        in_valid    <= 1;
        action      <= act;
        target_ip   <= ip;
        mac_addr    <= mac;
        iface_index <= iface;
        do @(posedge clk); while (!in_ready);
        arp_sb.note_item(act, ip, mac, iface);
        // Drop valid only when a gap follows; back-to-back items keep it high.
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until every expected result is back, then let the block settle.
    task automatic drain();
        in_valid <= 0;
        while (arp_sb.pending_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // APB write: setup then access; pready is always high.
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        if (addr == 3'(REG_TIMEOUT * 4)) arp_sb.timeout = data[7:0];
        else arp_sb.max_sends = data[3:0];
    endtask

    // Pick an address: mostly from the pool, sometimes fully random.
    function automatic logic [31:0] pick_ip();
        if ($urandom_range(0, 9) < 8) return ip_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic logic [47:0] rand_mac();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // One random phase: a biased mix of actions with ticks spread through it.
    task automatic random_phase(int count);
        int   roll;
        logic [2:0] act;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 20)      act = ACT_LOOKUP;
            else if (roll < 42) act = ACT_INSERT;
            else if (roll < 60) act = ACT_QUEUE;
            else if (roll < 70) act = ACT_REMOVE;
            else if (roll < 93) act = ACT_TICK;
            else if (roll < 96) act = ACT_CLEAR;
            else                act = 3'($urandom_range(6, 7));
            send_item(act, pick_ip(), rand_mac(), 4'($urandom()));
        end
    endtask

    initial begin
        arp_sb      = new();
        stim_done   = 0;
        in_valid    = 0;
        action      = 0;
        target_ip   = 0;
        mac_addr    = 0;
        iface_index = 0;
        psel        = 0;
        penable     = 0;
        pwrite      = 0;
        paddr       = 0;
        pwdata      = 0;
        foreach (ip_pool[i]) ip_pool[i] = $urandom();
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hFFFF_FFFF;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: field extremes and every action at reset config.
        send_item(ACT_LOOKUP, 32'h0, 48'h0, 4'h0);
        send_item(ACT_INSERT, 32'h0, 48'hFFFF_FFFF_FFFF, 4'hF);
        send_item(ACT_INSERT, 32'hFFFF_FFFF, 48'h0, 4'h0);
        send_item(ACT_INSERT, 32'h0, 48'h1234_5678_9ABC, 4'h0);   // duplicate IP
        send_item(ACT_LOOKUP, 32'h0, 48'h0, 4'h0);                // lowest slot wins
        send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0, 4'h0);
        send_item(ACT_QUEUE, 32'hFFFF_FFFF, 48'h0, 4'hF);
        send_item(ACT_QUEUE, 32'hFFFF_FFFF, 48'h0, 4'h3);         // already pending
        send_item(ACT_INSERT, 32'hFFFF_FFFF, 48'hA, 4'h0);        // pending request seen
        send_item(ACT_TICK, 32'h0, 48'h0, 4'h0);
        send_item(ACT_REMOVE, 32'hFFFF_FFFF, 48'h0, 4'h0);
        send_item(ACT_REMOVE, 32'h5, 48'h0, 4'h0);                // not pending
        send_item(3'd6, 32'h0, 48'h0, 4'h0);
        send_item(3'd7, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF);
        // Fill both tables past capacity.
        for (int i = 0; i < 17; i++) send_item(ACT_INSERT, 32'(i + 100), rand_mac(), 4'h0);
        for (int i = 0; i < 9; i++) send_item(ACT_QUEUE, 32'(i + 200), 48'h0, 4'(i));
        send_item(ACT_CLEAR, 32'h0, 48'h0, 4'h0);
        drain();

        // Random phases over several register settings, including the largest values.
        write_reg(3'(REG_TIMEOUT * 4), 32'd1);
        write_reg(3'(REG_MAXSEND * 4), 32'd1);
        random_phase(45);
        drain();
        write_reg(3'(REG_TIMEOUT * 4), 32'd255);
        write_reg(3'(REG_MAXSEND * 4), 32'd15);
        random_phase(55);
        drain();
        write_reg(3'(REG_TIMEOUT * 4), 32'd3);
        write_reg(3'(REG_MAXSEND * 4), 32'd2);
        random_phase(50);
        drain();
        write_reg(3'(REG_TIMEOUT * 4), 32'($urandom_range(1, 255)));
        write_reg(3'(REG_MAXSEND * 4), 32'($urandom_range(1, 15)));
        random_phase(45);
        stim_done = 1;
        drain();

        if (arp_sb.error_count == 0 && arp_sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

[arp_cache_with_aging_core.f]
hw/rtl/arp_pkg.sv
hw/rtl/arp_out_reg.sv
hw/rtl/arp_cache_with_aging_core.sv
sim/tb_top.sv
